// ===== sv/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg: shared constants of the page chain allocator
// Action codes, link codes, default geometry and stream word widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  // default table geometry
  localparam int unsigned PagesDefault     = 64;
  localparam int unsigned PagesPerSecDflt  = 16;

  // link codes held in the table
  localparam logic [7:0] CodeFree = 8'd255;
  localparam logic [7:0] CodeEnd  = 8'd254;

  // action codes
  localparam logic [2:0] ActAllocPage = 3'd0;
  localparam logic [2:0] ActAllocRun  = 3'd1;
  localparam logic [2:0] ActFreeChain = 3'd2;
  localparam logic [2:0] ActClearAll  = 3'd3;
  localparam logic [2:0] ActReadEntry = 3'd4;

  // stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

endpackage

`default_nettype wire

// ===== sv/pca_ram.sv =====
// ----------------------------------------------------------------------------
// pca_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/page_chain_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_chain_allocator_unit: next-page link table with chain allocation
// Links live in a RAM; a per-page in-use bitmap marks which entries hold a
// link, so a page whose bit is clear reads as free without touching the RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | word fields (lowest bit up)
//  s_axis   | in  | action[2:0] page[10:3] link_prev[11] prev_page[19:12]
//           |     | run_length[26:20]
//  m_axis   | out | ok[0] result_page[8:1] entry_link[16:9] entry_used[17]
//           |     | used_count[25:18]
//
// One word in flight at a time. alloc_page scans, then may link prev_page;
// alloc_run scans by sector, then fills the run; free_chain walks the chain;
// read_entry reads the RAM for a used page; the scan checks one page per cycle.
// Reset clears the bitmap and count at once: the table is free right after.
// A waiting result does not block the next input word; the sequencer holds in
// its final state only until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module page_chain_allocator_unit #(
  parameter int unsigned PAGES            = pca_pkg::PagesDefault,
  parameter int unsigned PAGES_PER_SECTOR = pca_pkg::PagesPerSecDflt
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // action, page, link_prev, prev_page, run_length
  input  wire logic [pca_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // ok, result_page, entry_link, entry_used, used_count
  output logic      [pca_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned CW = $clog2(PAGES_PER_SECTOR + 1);

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StScan   = 9'b000000010,
    StLink   = 9'b000000100,
    StRScan  = 9'b000001000,
    StRFill  = 9'b000010000,
    StWalk   = 9'b000100000,
    StWalkWt = 9'b001000000,
    StReadWt = 9'b010000000,
    StDone   = 9'b100000000
  } state_e;

  // input fields
  logic [2:0] in_action;
  logic [7:0] in_page;
  logic       in_link_prev;
  logic [7:0] in_prev_page;
  logic [6:0] in_run_length;

  assign in_action     = s_axis_tdata[2:0];
  assign in_page       = s_axis_tdata[10:3];
  assign in_link_prev  = s_axis_tdata[11];
  assign in_prev_page  = s_axis_tdata[19:12];
  assign in_run_length = s_axis_tdata[26:20];

  state_e            state_q, state_d;
  logic [PAGES-1:0]  used_q, used_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [7:0]        p_q, p_d;
  logic [7:0]        s_q, s_d;
  logic [CW-1:0]     i_q, i_d;
  logic [6:0]        w_q, w_d;
  logic [6:0]        len_q, len_d;
  logic              link_q, link_d;
  logic [7:0]        prev_q, prev_d;
  logic              res_ok_q, res_ok_d;
  logic [7:0]        res_page_q, res_page_d;
  logic [7:0]        res_link_q, res_link_d;
  logic              res_used_q, res_used_d;
  logic              m_valid_q, m_valid_d;
  logic [pca_pkg::OutDataW-1:0] m_data_q, m_data_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  logic              accept;
  logic              out_free;
  logic [8:0]        sec_next;
  logic [7:0]        fill_addr;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign sec_next      = {1'b0, s_q} + 9'(PAGES_PER_SECTOR);
  assign fill_addr     = s_q + {1'b0, w_q};

  pca_ram #(
    .Width (8),
    .Depth (PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    cnt_d      = cnt_q;
    p_d        = p_q;
    s_d        = s_q;
    i_d        = i_q;
    w_d        = w_q;
    len_d      = len_q;
    link_d     = link_q;
    prev_d     = prev_q;
    res_ok_d   = res_ok_q;
    res_page_d = res_page_q;
    res_link_d = res_link_q;
    res_used_d = res_used_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    ram_we     = 1'b0;
    ram_waddr  = p_q[AW-1:0];
    ram_wdata  = pca_pkg::CodeEnd;
    ram_raddr  = (state_q == StIdle) ? in_page[AW-1:0] : p_q[AW-1:0];

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_ok_d   = 1'b1;
          res_page_d = 8'd0;
          res_link_d = 8'd0;
          res_used_d = 1'b0;
          state_d    = StDone;
          case (in_action)
            pca_pkg::ActAllocPage: begin
              p_d     = 8'd0;
              link_d  = in_link_prev;
              prev_d  = in_prev_page;
              state_d = StScan;
            end
            pca_pkg::ActAllocRun: begin
              if (in_run_length == 7'd0 || in_run_length > 7'(PAGES_PER_SECTOR)
                  || PAGES_PER_SECTOR > PAGES) begin
                res_ok_d = 1'b0;
              end else begin
                s_d     = 8'd0;
                p_d     = 8'd0;
                i_d     = '0;
                len_d   = in_run_length;
                state_d = StRScan;
              end
            end
            pca_pkg::ActFreeChain: begin
              p_d     = in_page;
              state_d = StWalk;
            end
            pca_pkg::ActClearAll: begin
              used_d = '0;
              cnt_d  = 8'd0;
            end
            pca_pkg::ActReadEntry: begin
              if (in_page < 8'(PAGES) && used_q[in_page[AW-1:0]]) begin
                state_d = StReadWt;
              end else begin
                res_link_d = pca_pkg::CodeFree;
              end
            end
            default: ;
          endcase
        end
      end

      StScan: begin
        if (!used_q[p_q[AW-1:0]]) begin
          ram_we                = 1'b1;
          used_d[p_q[AW-1:0]]   = 1'b1;
          cnt_d                 = cnt_q + 8'd1;
          res_page_d            = p_q;
          state_d = (link_q && prev_q < 8'(PAGES)) ? StLink : StDone;
        end else if (p_q == 8'(PAGES - 1)) begin
          res_ok_d = 1'b0;
          state_d  = StDone;
        end else begin
          p_d = p_q + 8'd1;
        end
      end

      StLink: begin
        ram_we    = 1'b1;
        ram_waddr = prev_q[AW-1:0];
        ram_wdata = res_page_q;
        if (!used_q[prev_q[AW-1:0]]) begin
          cnt_d = cnt_q + 8'd1;
        end
        used_d[prev_q[AW-1:0]] = 1'b1;
        state_d = StDone;
      end

      StRScan: begin
        if (used_q[p_q[AW-1:0]]) begin
          // skip to the next sector
          if (sec_next + 9'(PAGES_PER_SECTOR) > 9'(PAGES)) begin
            res_ok_d = 1'b0;
            state_d  = StDone;
          end else begin
            s_d = sec_next[7:0];
            p_d = sec_next[7:0];
            i_d = '0;
          end
        end else if (i_q == CW'(PAGES_PER_SECTOR - 1)) begin
          w_d        = 7'd0;
          res_page_d = s_q;
          state_d    = StRFill;
        end else begin
          p_d = p_q + 8'd1;
          i_d = i_q + CW'(1);
        end
      end

      StRFill: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr[AW-1:0];
        ram_wdata = (w_q + 7'd1 < len_q) ? fill_addr + 8'd1 : pca_pkg::CodeEnd;
        used_d[fill_addr[AW-1:0]] = 1'b1;
        cnt_d = cnt_q + 8'd1;
        if (w_q + 7'd1 == len_q) begin
          state_d = StDone;
        end else begin
          w_d = w_q + 7'd1;
        end
      end

      StWalk: begin
        // stop at an out-of-range index or a page already free
        if (p_q >= 8'(PAGES)) begin
          state_d = StDone;
        end else if (!used_q[p_q[AW-1:0]]) begin
          state_d = StDone;
        end else begin
          state_d = StWalkWt;
        end
      end

      StWalkWt: begin
        used_d[p_q[AW-1:0]] = 1'b0;
        cnt_d = cnt_q - 8'd1;
        if (ram_rdata == pca_pkg::CodeEnd) begin
          state_d = StDone;
        end else begin
          p_d     = ram_rdata;
          state_d = StWalk;
        end
      end

      StReadWt: begin
        res_link_d = ram_rdata;
        res_used_d = 1'b1;
        state_d    = StDone;
      end

      StDone: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, cnt_q, res_used_q, res_link_q, res_page_q, res_ok_q};
          state_d   = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      used_q    <= '0;
      cnt_q     <= 8'd0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    s_q        <= s_d;
    i_q        <= i_d;
    w_q        <= w_d;
    len_q      <= len_d;
    link_q     <= link_d;
    prev_q     <= prev_d;
    res_ok_q   <= res_ok_d;
    res_page_q <= res_page_d;
    res_link_q <= res_link_d;
    res_used_q <= res_used_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the page chain allocator
// Drives action words on s_axis and checks every reply word on m_axis against
// a mirror of the link table or a typed reply. A short table of directed words comes
// first, then random chain traffic in phases with different idle and stall
// rates, one of them with a long receiver hold that backs up the input.
// ----------------------------------------------------------------------------

module tb_top;
  import pca_pkg::*;

  localparam int unsigned PAGES      = PagesDefault;
  localparam int unsigned SECT       = PagesPerSecDflt;
  localparam int unsigned RandPerPh  = 125;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned CycleLimit = 600000;

  // action codes the block leaves undecoded
  localparam logic [2:0] ActSpareLo = 3'd5;
  localparam logic [2:0] ActSpareHi = 3'd7;

  // action word, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0] run_length;
    logic [7:0] prev_page;
    logic       link_prev;
    logic [7:0] page;
    logic [2:0] action;
  } cmd_t;

  // reply word, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0] used_count;
    logic       entry_used;
    logic [7:0] entry_link;
    logic [7:0] result_page;
    logic       ok;
  } reply_t;

  typedef struct {
    cmd_t   cmd;
    bit     typed;
    reply_t want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [7:0]  link_mirror [PAGES];
  reply_t      reply_q [$];
  row_t        plan [$];
  int unsigned chain_heads [$];
  int          chain_tail = -1;
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        hold_armed = 1'b0;
  bit          hold_done = 1'b0;

  page_chain_allocator_unit #(
    .PAGES           (PAGES),
    .PAGES_PER_SECTOR(SECT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Apply one action to the mirror table and return the reply it produces.
  function automatic reply_t alloc_reply(cmd_t c);
    reply_t      r;
    int unsigned i, s, p, steps, n, got;
    logic [7:0]  nx;
    bit          found, clean, done;
    r = '0;
    r.ok = 1'b1;
    case (c.action)
      ActAllocPage: begin
        found = 1'b0;
        got = 0;
        for (i = 0; i < PAGES && !found; i++) begin
          if (link_mirror[i] == CodeFree) begin
            found = 1'b1;
            got = i;
          end
        end
        if (found) begin
          link_mirror[got] = CodeEnd;
          if (c.link_prev && c.prev_page < PAGES) link_mirror[c.prev_page] = 8'(got);
          r.result_page = 8'(got);
        end else begin
          r.ok = 1'b0;
        end
      end
      ActAllocRun: begin
        r.ok = 1'b0;
        if (c.run_length != 0 && c.run_length <= SECT) begin
          for (s = 0; s + SECT <= PAGES && !r.ok; s += SECT) begin
            clean = 1'b1;
            for (i = 0; i < SECT; i++)
              if (link_mirror[s+i] != CodeFree) clean = 1'b0;
            if (clean) begin
              for (i = 0; i < c.run_length; i++)
                link_mirror[s+i] = (i + 1 < c.run_length) ? 8'(s + i + 1) : CodeEnd;
              r.ok = 1'b1;
              r.result_page = 8'(s);
            end
          end
        end
      end
      ActFreeChain: begin
        p = c.page;
        steps = 0;
        done = 1'b0;
        // stop on out of range, an already free entry, end code or loop guard
        while (!done && p < PAGES && link_mirror[p] != CodeFree && steps <= PAGES) begin
          nx = link_mirror[p];
          steps++;
          link_mirror[p] = CodeFree;
          if (nx == CodeEnd) done = 1'b1;
          else p = nx;
        end
      end
      ActClearAll: begin
        foreach (link_mirror[k]) link_mirror[k] = CodeFree;
      end
      ActReadEntry: begin
        if (c.page < PAGES) begin
          r.entry_link = link_mirror[c.page];
          r.entry_used = (link_mirror[c.page] != CodeFree);
        end else begin
          r.entry_link = CodeFree;
        end
      end
      default: ;
    endcase
    n = 0;
    foreach (link_mirror[k]) if (link_mirror[k] != CodeFree) n++;
    r.used_count = 8'(n);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [2:0] act, logic [7:0] pg, logic lp,
                                  logic [7:0] prev, logic [6:0] len);
    cmd_t c;
    c.action = act;
    c.page = pg;
    c.link_prev = lp;
    c.prev_page = prev;
    c.run_length = len;
    return c;
  endfunction

  function automatic reply_t mk_reply(logic ok, logic [7:0] rp, logic [7:0] lnk,
                                      logic used, logic [7:0] cnt);
    reply_t r;
    r.ok = ok;
    r.result_page = rp;
    r.entry_link = lnk;
    r.entry_used = used;
    r.used_count = cnt;
    return r;
  endfunction

  task automatic add_row(input cmd_t c, input bit typed, input reply_t want);
    row_t w;
    w.cmd = c;
    w.typed = typed;
    w.want = want;
    plan.push_back(w);
  endtask

  // Mostly grow and free real chains, with some noise mixed in.
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned w, k;
    c = mk_cmd(3'($urandom_range(4)), 8'($urandom_range(255)), 1'($urandom_range(1)),
               8'($urandom_range(253)), 7'($urandom_range(64)));
    w = $urandom_range(99);
    if (w < 40) begin
      c.action = ActAllocPage;
      c.link_prev = ($urandom_range(99) < 75);
      if (chain_tail >= 0 && $urandom_range(3) != 0) c.prev_page = 8'(chain_tail);
    end else if (w < 55) begin
      c.action = ActAllocRun;
      if ($urandom_range(9) != 0) c.run_length = 7'($urandom_range(SECT, 1));
    end else if (w < 75) begin
      c.action = ActFreeChain;
      if (chain_heads.size() != 0 && $urandom_range(4) != 0) begin
        k = $urandom_range(chain_heads.size() - 1);
        c.page = 8'(chain_heads[k]);
        chain_heads.delete(k);
      end
    end else if (w < 77) begin
      c.action = ActClearAll;
    end else if (w < 95) begin
      c.action = ActReadEntry;
      if ($urandom_range(9) != 0) c.page = 8'($urandom_range(PAGES - 1));
    end else begin
      c.action = 3'($urandom_range(ActSpareHi, ActSpareLo));
    end
    return c;
  endfunction

  // Offer one word and return at the edge where it is taken.
  task automatic push_word(input cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - $bits(cmd_t)){1'b0}}, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic issue(input cmd_t c, input bit typed, input reply_t want);
    reply_t r;
    push_word(c);
    r = alloc_reply(c);
    reply_q.push_back(typed ? want : r);
    // track chain heads and the tail being extended
    if (c.action == ActClearAll) begin
      chain_heads.delete();
      chain_tail = -1;
    end else if (c.action == ActAllocPage && r.ok) begin
      if (!(c.link_prev && c.prev_page == chain_tail)) chain_heads.push_back(r.result_page);
      chain_tail = r.result_page;
    end else if (c.action == ActAllocRun && r.ok) begin
      chain_heads.push_back(r.result_page);
    end
    if (chain_heads.size() > 16) void'(chain_heads.pop_front());
  endtask

  task automatic report_bad(input string what, input reply_t want, input reply_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: exp ok=%0d page=%0d link=%0d used=%0d cnt=%0d, got ok=%0d page=%0d link=%0d used=%0d cnt=%0d",
               $realtime, what, want.ok, want.result_page, want.entry_link, want.entry_used,
               want.used_count, got.ok, got.result_page, got.entry_link, got.entry_used,
               got.used_count);
  endtask

  // stimulus
  initial begin
    int unsigned ph;
    foreach (link_mirror[k]) link_mirror[k] = CodeFree;

    add_row(mk_cmd(ActReadEntry, 8'd0, 1'b0, 8'd0, 7'd0), 1, mk_reply(1, 0, CodeFree, 0, 0));
    add_row(mk_cmd(ActReadEntry, 8'd255, 1'b0, 8'd0, 7'd0), 1,
            mk_reply(1, 0, CodeFree, 0, 0));
    add_row(mk_cmd(ActAllocPage, 8'd0, 1'b0, 8'd0, 7'd0), 1, mk_reply(1, 0, 0, 0, 1));
    add_row(mk_cmd(ActAllocPage, 8'd0, 1'b1, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActAllocPage, 8'd0, 1'b1, 8'd253, 7'd0), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'(SECT + 1)), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'(SECT)), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'd1), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'd64), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'(SECT)), 0, '0);
    add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'd1), 0, '0);
    add_row(mk_cmd(ActReadEntry, 8'(SECT), 1'b0, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActFreeChain, 8'd0, 1'b0, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActFreeChain, 8'd255, 1'b0, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActFreeChain, 8'd5, 1'b0, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActSpareLo, 8'd255, 1'b1, 8'd253, 7'd64), 0, '0);
    add_row(mk_cmd(ActSpareHi, 8'd255, 1'b1, 8'd253, 7'd64), 0, '0);
    add_row(mk_cmd(ActClearAll, 8'd0, 1'b0, 8'd0, 7'd0), 1, mk_reply(1, 0, 0, 0, 0));
    // page 0 linked to itself: the walk must still end
    add_row(mk_cmd(ActAllocPage, 8'd0, 1'b1, 8'd0, 7'd0), 0, '0);
    add_row(mk_cmd(ActFreeChain, 8'd0, 1'b0, 8'd0, 7'd0), 0, '0);
    repeat (PAGES / SECT) add_row(mk_cmd(ActAllocRun, 8'd0, 1'b0, 8'd0, 7'(SECT)), 0, '0);
    add_row(mk_cmd(ActAllocPage, 8'd0, 1'b0, 8'd0, 7'd0), 1, mk_reply(0, 0, 0, 0, 8'(PAGES)));
    add_row(mk_cmd(ActReadEntry, 8'(PAGES - 1), 1'b0, 8'd0, 7'd0), 1,
            mk_reply(1, 0, CodeEnd, 1, 8'(PAGES)));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 13;
    recv_stall = 13;
    foreach (plan[i]) issue(plan[i].cmd, plan[i].typed, plan[i].want);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle = 0;
          recv_stall = 0;
          hold_armed <= 1'b1;
        end
        1: begin
          send_idle = 69;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 69;
        end
        default: begin
          send_idle = 13;
          recv_stall = 13;
        end
      endcase
      repeat (RandPerPh) issue(rand_cmd(), 0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // output side: random stalls plus one long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_armed && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reply_t'(m_axis_tdata[$bits(reply_t)-1:0]);
      if (reply_q.size() == 0) begin
        report_bad("reply with none pending", '0, got);
      end else begin
        want = reply_q.pop_front();
        if (got.ok !== want.ok || got.result_page !== want.result_page ||
            got.entry_link !== want.entry_link || got.entry_used !== want.entry_used ||
            got.used_count !== want.used_count)
          report_bad("reply mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
